// File: sv/cartridge_bank_switch_mapper_defines.svh
// Assertion macros shared by the mapper RTL.
`ifndef CARTRIDGE_BANK_SWITCH_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_SWITCH_MAPPER_DEFINES_SVH

`ifndef SYNTH

// Property checked on every rising clock edge while reset is low.
`define CBSM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define CBSM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CBSM_ASSERT(label, clk, rst, prop, msg)
`define CBSM_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: sv/cbsm_pkg.sv
`default_nettype none

package cbsm_pkg;

   // Field widths of the bus access and of the result.
   localparam int ADDR_W = 16;
   localparam int DATA_W = 8;
   localparam int MAP_W  = 17;
   localparam int KIND_W = 2;
   localparam int TGT_W  = 3;
   localparam int SEL_W  = 3;

   // Number of switchable banks.
   localparam int PRG_BANKS = 2;
   localparam int CHR_BANKS = 6;

   // Register decode: address under the mask selects selector or bank data.
   localparam logic [ADDR_W-1:0] REG_ADDR_MASK = 16'hE001;
   localparam logic [ADDR_W-1:0] SEL_REG_ADDR  = 16'h8000;
   localparam logic [ADDR_W-1:0] BANK_REG_ADDR = 16'h8001;

   // Program banks fixed in the last two slots.
   localparam logic [3:0] PRG_FIXED_SLOT2 = 4'hE;
   localparam logic [3:0] PRG_FIXED_SLOT3 = 4'hF;

   // Selector codes: two 2 KiB character banks, four 1 KiB, two program.
   localparam logic [SEL_W-1:0] SEL_CHR_2K_FIRST = 3'd0;
   localparam logic [SEL_W-1:0] SEL_CHR_2K_LAST  = 3'd1;
   localparam logic [SEL_W-1:0] SEL_CHR_1K_FIRST = 3'd2;
   localparam logic [SEL_W-1:0] SEL_CHR_1K_LAST  = 3'd5;
   localparam logic [SEL_W-1:0] CHR_1K_BASE      = 3'd2;

   typedef enum logic [KIND_W-1:0] {
      REQ_PRG_READ  = 2'd0,
      REQ_PRG_WRITE = 2'd1,
      REQ_CHR_READ  = 2'd2,
      REQ_CHR_WRITE = 2'd3
   } req_kind_type;

   typedef enum logic [TGT_W-1:0] {
      TGT_PRG_ROM  = 3'd0,
      TGT_CHR_ROM  = 3'd1,
      TGT_CONS_RAM = 3'd2,
      TGT_CART_RAM = 3'd3,
      TGT_NONE     = 3'd4
   } target_type;

   // Register write request from the decode to the bank registers.
   typedef struct packed {
      logic              sel_we;
      logic              bank_we;
      logic [DATA_W-1:0] data;
   } bank_wr_type;

   // One translated access.
   typedef struct packed {
      target_type        target;
      logic [MAP_W-1:0]  mapped_address;
      logic              write_enable;
      logic [DATA_W-1:0] data_out;
   } rsp_type;

endpackage

`default_nettype wire

// File: sv/cartridge_bank_switch_mapper.sv
// Throughput: one request per cycle while the result channel is not stalled;
// each request takes one pass through the address decode between the
// request register and the result register.
// Reset (synchronous, active high) clears both valid flags, the bank
// selector and all bank registers to zero.
`default_nettype none

`include "cartridge_bank_switch_mapper_defines.svh"

module cartridge_bank_switch_mapper #(
   parameter int PRG_BANK_BITS = 4,
   parameter int CHR_BANK_BITS = 6
) (
   input  wire         clock,
   input  wire         reset,
   // Request channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // bus_address[15:0], bus_data[23:16]
   input  wire  [1:0]  req_tuser,   // req_type[1:0]
   // Result channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // mapped_address[16:0], write_enable[17],
                                    // data_out[25:18], zero[31:26]
   output logic [2:0]  rsp_tuser    // target[2:0]
);
   import cbsm_pkg::*;

   logic                                     req_valid_ff;
   logic                                     req_valid_in;
   req_kind_type                             req_kind_ff;
   logic [ADDR_W-1:0]                        req_addr_ff;
   logic [DATA_W-1:0]                        req_data_ff;
   logic                                     rsp_valid_ff;
   logic                                     rsp_valid_in;
   rsp_type                                  rsp_ff;
   rsp_type                                  xlate_rsp;
   bank_wr_type                              xlate_wr;
   bank_wr_type                              bank_wr;
   logic                                     advance;
   logic                                     req_take;
   logic [PRG_BANKS-1:0][PRG_BANK_BITS-1:0]  prg_bank;
   logic [CHR_BANKS-1:0][CHR_BANK_BITS-1:0]  chr_bank;

   // Handshake: the request register moves on whenever the result slot frees.
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !req_valid_ff || advance;
   assign req_take     = req_tvalid && req_tready;
   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request payload register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_kind_ff <= req_kind_type'(req_tuser);
         req_addr_ff <= req_tdata[15:0];
         req_data_ff <= req_tdata[23:16];
      end
   end

   cbsm_translate #(
      .PRG_BANK_BITS (PRG_BANK_BITS),
      .CHR_BANK_BITS (CHR_BANK_BITS)
   ) u_translate (
      .kind        (req_kind_ff),
      .bus_address (req_addr_ff),
      .bus_data    (req_data_ff),
      .prg_bank    (prg_bank),
      .chr_bank    (chr_bank),
      .rsp         (xlate_rsp),
      .wr          (xlate_wr)
   );

   // Register writes take effect only as their request leaves the stage.
   always_comb begin
      bank_wr         = xlate_wr;
      bank_wr.sel_we  = xlate_wr.sel_we && advance;
      bank_wr.bank_we = xlate_wr.bank_we && advance;
   end

   cbsm_bank_regs #(
      .PRG_BANK_BITS (PRG_BANK_BITS),
      .CHR_BANK_BITS (CHR_BANK_BITS)
   ) u_bank_regs (
      .clock    (clock),
      .reset    (reset),
      .wr       (bank_wr),
      .prg_bank (prg_bank),
      .chr_bank (chr_bank)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= xlate_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.target;
   assign rsp_tdata  = {6'b0, rsp_ff.data_out, rsp_ff.write_enable, rsp_ff.mapped_address};

   // Only nametable RAM is ever written.
   `CBSM_ASSERT(a_we_ram_only, clock, reset,
      rsp_valid_ff && rsp_ff.write_enable |->
         (rsp_ff.target == TGT_CONS_RAM || rsp_ff.target == TGT_CART_RAM),
      "write enable on non-RAM target")
   // An access that reaches nothing carries a zero address.
   `CBSM_ASSERT(a_none_zero_addr, clock, reset,
      rsp_valid_ff && rsp_ff.target == TGT_NONE |-> rsp_ff.mapped_address == '0,
      "nonzero address with no target")
   // A held request stays in place until it can move on.
   `CBSM_ASSERT(a_req_hold, clock, reset,
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_addr_ff)
         && $stable(req_data_ff),
      "held request lost or changed")
   // Bank registers are written only while a request moves on.
   `CBSM_ASSERT(a_wr_on_advance, clock, reset,
      !(bank_wr.sel_we || bank_wr.bank_we) || advance, "register write without advance")

endmodule

`default_nettype wire

// File: sv/cbsm_bank_regs.sv
`default_nettype none

`include "cartridge_bank_switch_mapper_defines.svh"

module cbsm_bank_regs #(
   parameter int PRG_BANK_BITS = 4,
   parameter int CHR_BANK_BITS = 6
) (
   input  wire                                                    clock,
   input  wire                                                    reset,
   input  cbsm_pkg::bank_wr_type                                  wr,
   output logic [cbsm_pkg::PRG_BANKS-1:0][PRG_BANK_BITS-1:0]      prg_bank,
   output logic [cbsm_pkg::CHR_BANKS-1:0][CHR_BANK_BITS-1:0]      chr_bank
);
   import cbsm_pkg::*;

   logic [SEL_W-1:0]                         selector_ff;
   logic [SEL_W-1:0]                         selector_in;
   logic [PRG_BANKS-1:0][PRG_BANK_BITS-1:0]  prg_ff;
   logic [PRG_BANKS-1:0][PRG_BANK_BITS-1:0]  prg_in;
   logic [CHR_BANKS-1:0][CHR_BANK_BITS-1:0]  chr_ff;
   logic [CHR_BANKS-1:0][CHR_BANK_BITS-1:0]  chr_in;

   // Selector write, then a data write to the bank the selector names.
   always_comb begin
      selector_in = selector_ff;
      prg_in      = prg_ff;
      chr_in      = chr_ff;
      if (wr.sel_we) begin
         selector_in = wr.data[SEL_W-1:0];
      end
      if (wr.bank_we) begin
         if (selector_ff inside {[SEL_CHR_2K_FIRST:SEL_CHR_2K_LAST]}) begin
            // 2 KiB banks keep an even bank number.
            chr_in[selector_ff]    = wr.data[CHR_BANK_BITS-1:0];
            chr_in[selector_ff][0] = 1'b0;
         end else if (selector_ff inside {[SEL_CHR_1K_FIRST:SEL_CHR_1K_LAST]}) begin
            chr_in[selector_ff] = wr.data[CHR_BANK_BITS-1:0];
         end else begin
            prg_in[selector_ff[0]] = wr.data[PRG_BANK_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         selector_ff <= '0;
         prg_ff      <= '0;
         chr_ff      <= '0;
      end else begin
         selector_ff <= selector_in;
         prg_ff      <= prg_in;
         chr_ff      <= chr_in;
      end
   end

   assign prg_bank = prg_ff;
   assign chr_bank = chr_ff;

   // The 2 KiB bank registers never hold an odd bank.
   `CBSM_ASSERT(a_chr_2k_even, clock, reset,
      chr_ff[0][0] == 1'b0 && chr_ff[1][0] == 1'b0, "odd 2 KiB character bank")
   // Bank registers move only on a bank data write.
   `CBSM_ASSERT(a_bank_stable, clock, reset,
      !wr.bank_we |=> $stable(chr_ff) && $stable(prg_ff), "bank changed without write")
   // The selector moves only on a selector write.
   `CBSM_ASSERT(a_sel_stable, clock, reset,
      !wr.sel_we |=> $stable(selector_ff), "selector changed without write")

endmodule

`default_nettype wire

// File: sv/cbsm_translate.sv
`default_nettype none

module cbsm_translate #(
   parameter int PRG_BANK_BITS = 4,
   parameter int CHR_BANK_BITS = 6
) (
   input  cbsm_pkg::req_kind_type                                 kind,
   input  wire  [cbsm_pkg::ADDR_W-1:0]                            bus_address,
   input  wire  [cbsm_pkg::DATA_W-1:0]                            bus_data,
   input  wire  [cbsm_pkg::PRG_BANKS-1:0][PRG_BANK_BITS-1:0]      prg_bank,
   input  wire  [cbsm_pkg::CHR_BANKS-1:0][CHR_BANK_BITS-1:0]      chr_bank,
   output cbsm_pkg::rsp_type                                      rsp,
   output cbsm_pkg::bank_wr_type                                  wr
);
   import cbsm_pkg::*;

   logic [PRG_BANK_BITS-1:0] prg_sel_bank;
   logic [SEL_W-1:0]         chr_1k_idx;
   logic [ADDR_W-1:0]        reg_match;

   // Program slot to bank: two switchable slots, then banks 14 and 15.
   always_comb begin
      case (bus_address[14:13])
         2'd0:    prg_sel_bank = prg_bank[0];
         2'd1:    prg_sel_bank = prg_bank[1];
         2'd2:    prg_sel_bank = PRG_BANK_BITS'(PRG_FIXED_SLOT2);
         default: prg_sel_bank = PRG_BANK_BITS'(PRG_FIXED_SLOT3);
      endcase
   end

   assign chr_1k_idx = CHR_1K_BASE + {1'b0, bus_address[11:10]};
   assign reg_match  = bus_address & REG_ADDR_MASK;

   // Decode the access kind and address range into a target and address.
   always_comb begin
      rsp.target         = TGT_NONE;
      rsp.mapped_address = '0;
      rsp.write_enable   = 1'b0;
      rsp.data_out       = bus_data;
      wr.sel_we          = 1'b0;
      wr.bank_we         = 1'b0;
      wr.data            = bus_data;
      case (kind)
         REQ_PRG_READ: begin
            if (bus_address[15]) begin
               rsp.target         = TGT_PRG_ROM;
               rsp.mapped_address = MAP_W'({prg_sel_bank, bus_address[12:0]});
               rsp.data_out       = '0;
            end
         end
         REQ_PRG_WRITE: begin
            wr.sel_we  = (reg_match == SEL_REG_ADDR);
            wr.bank_we = (reg_match == BANK_REG_ADDR);
         end
         REQ_CHR_READ, REQ_CHR_WRITE: begin
            if (bus_address[15:13] == 3'd0) begin
               // Pattern area: ROM, read only.
               if (kind == REQ_CHR_READ) begin
                  rsp.target   = TGT_CHR_ROM;
                  rsp.data_out = '0;
                  if (!bus_address[12]) begin
                     // The 2 KiB bank counts in 1 KiB units and overlaps the offset.
                     rsp.mapped_address =
                        MAP_W'({chr_bank[bus_address[11]], 10'b0}) |
                        MAP_W'(bus_address[10:0]);
                  end else begin
                     rsp.mapped_address =
                        MAP_W'({chr_bank[chr_1k_idx], bus_address[9:0]});
                  end
               end
            end else if (bus_address[15:12] == 4'h2) begin
               // Nametable area: lower half console RAM, upper half cartridge RAM.
               rsp.target         = bus_address[11] ? TGT_CART_RAM : TGT_CONS_RAM;
               rsp.mapped_address = MAP_W'(bus_address[10:0]);
               if (kind == REQ_CHR_WRITE) begin
                  rsp.write_enable = 1'b1;
               end else begin
                  rsp.data_out = '0;
               end
            end
         end
         default: begin
            rsp.target = TGT_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire
